@@ hdl/vdpcpu_pkg.sv @@
// Shared types and constants for the VDP CPU-port video RAM access block.
// Holds the access kind codes, the back-end operation codes and the command
// record that travels from the front end to the back end. No dependencies.
package vdpcpu_pkg;

  // Widest address any build of the block uses; the command record carries this.
  localparam int unsigned AddrMaxBits = 16;
  localparam int unsigned AddrOutBits = 14;

  // Access kinds as presented on the input channel.
  typedef enum logic [2:0] {
    KIND_DATA_READ   = 3'd0,
    KIND_DATA_WRITE  = 3'd1,
    KIND_ADDR_WRITE  = 3'd2,
    KIND_STATUS_READ = 3'd3,
    KIND_DIRECT_SET  = 3'd4
  } kind_e;

  // What the back end does with one command.
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,  // no RAM access, result zero
    OP_READ   = 3'd1,  // return read-ahead byte, then refill it
    OP_WRITE  = 3'd2,  // store byte, read-ahead byte takes it too
    OP_FETCH  = 3'd3,  // refill read-ahead byte, result zero
    OP_STATUS = 3'd4   // pass status byte through
  } op_e;

  typedef struct packed {
    op_e                    op;
    logic [AddrMaxBits-1:0] ram_addr;
    logic [7:0]             wdata;     // write byte, or status byte
    logic [AddrOutBits-1:0] addr_now;
  } cmd_t;

endpackage

@@ hdl/vdpcpu_front.sv @@
// Front end: accepts access items, keeps the auto-increment address and the
// address-write flip-flop, and turns each item into a back-end command.
// Depends on vdpcpu_pkg.
module vdpcpu_front import vdpcpu_pkg::*; #(
  parameter int unsigned ADDR_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] set_address_i,
  input  logic [7:0]  status_byte_i,
  output cmd_t        cmd_o
);

  logic [ADDR_BITS-1:0] cur_q, cur_d;
  logic                 second_q, second_d;
  logic [15:0]          cur16;
  logic [15:0]          new16;
  logic [15:0]          next16;
  logic [ADDR_BITS-1:0] new_addr;

  assign cur16 = 16'(cur_q);

  always_comb begin
    cur_d        = cur_q;
    second_d     = second_q;
    new16        = '0;
    new_addr     = '0;
    cmd_o.op       = OP_NONE;
    cmd_o.ram_addr = 16'(cur_q);
    cmd_o.wdata    = data_byte_i;
    unique case (kind_i)
      KIND_DATA_READ: begin
        cmd_o.op = OP_READ;
        cur_d    = cur_q + 1'b1;
        second_d = 1'b0;
      end
      KIND_DATA_WRITE: begin
        cmd_o.op = OP_WRITE;
        cur_d    = cur_q + 1'b1;
        second_d = 1'b0;
      end
      KIND_ADDR_WRITE: begin
        if (second_q) begin
          new16    = {2'b00, data_byte_i[5:0], cur16[7:0]};
          new_addr = new16[ADDR_BITS-1:0];
          second_d = 1'b0;
          if (data_byte_i[7:6] == 2'b00) begin
            cmd_o.op       = OP_FETCH;
            cmd_o.ram_addr = 16'(new_addr);
            cur_d          = new_addr + 1'b1;
          end else begin
            cur_d = new_addr;
          end
        end else begin
          new16    = {cur16[15:8], data_byte_i};
          cur_d    = new16[ADDR_BITS-1:0];
          second_d = 1'b1;
        end
      end
      KIND_STATUS_READ: begin
        cmd_o.op    = OP_STATUS;
        cmd_o.wdata = status_byte_i;
        second_d    = 1'b0;
      end
      KIND_DIRECT_SET: begin
        second_d = 1'b0;
        new_addr = set_address_i[ADDR_BITS-1:0];
        if (set_address_i[15:14] != 2'b00) begin
          cur_d = new_addr;
        end else begin
          cmd_o.op       = OP_FETCH;
          cmd_o.ram_addr = 16'(new_addr);
          cur_d          = new_addr + 1'b1;
        end
      end
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase
    next16         = 16'(cur_d);
    cmd_o.addr_now = next16[AddrOutBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q    <= '0;
      second_q <= 1'b0;
    end else if (accept_i) begin
      cur_q    <= cur_d;
      second_q <= second_d;
    end
  end

endmodule

@@ hdl/vdpcpu_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on vdpcpu_pkg.
module vdpcpu_queue import vdpcpu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o    = (count_q == 2'd2);
  assign valid_o   = (count_q != 2'd0);
  assign pop_cmd_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ hdl/vdpcpu_back.sv @@
// Back end: owns the video RAM and the read-ahead byte, executes commands
// and drives the registered result item. Depends on vdpcpu_pkg.
module vdpcpu_back import vdpcpu_pkg::*; #(
  parameter int unsigned ADDR_BITS = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  input  cmd_t                   cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             read_data_o,
  output logic [AddrOutBits-1:0] address_now_o
);

  localparam int unsigned RamDepth = 2 ** ADDR_BITS;

  logic [7:0]           mem [RamDepth];
  logic [7:0]           ram_q;
  logic                 pend_q;     // ram_q holds a refill not yet in ra_q
  logic [7:0]           ra_q;
  logic [7:0]           ra_cur;
  logic                 out_valid_q;
  logic [7:0]           read_data_q;
  logic [AddrOutBits-1:0] addr_now_q;
  logic [ADDR_BITS-1:0] ram_addr;
  logic                 do_write, do_fetch;
  logic [7:0]           result;

  assign pop_o    = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign ram_addr = cmd_i.ram_addr[ADDR_BITS-1:0];
  assign do_write = pop_o && (cmd_i.op == OP_WRITE);
  assign do_fetch = pop_o && (cmd_i.op == OP_READ || cmd_i.op == OP_FETCH);
  assign ra_cur   = pend_q ? ram_q : ra_q;

  always_comb begin
    case (cmd_i.op)
      OP_READ:   result = ra_cur;
      OP_STATUS: result = cmd_i.wdata;
      default:   result = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_write) mem[ram_addr] <= cmd_i.wdata;
    if (do_fetch) ram_q <= mem[ram_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      ra_q        <= 8'h00;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= do_fetch || (pend_q && !do_write);
      if (do_write) begin
        ra_q <= cmd_i.wdata;
      end else if (pend_q) begin
        ra_q <= ram_q;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      read_data_q <= result;
      addr_now_q  <= cmd_i.addr_now;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = read_data_q;
  assign address_now_o = addr_now_q;

endmodule

@@ hdl/vdp_cpu_port_vram_access_top.sv @@
// Top level of the VDP CPU-port video RAM access block: front end, command
// queue and back end. Depends on vdpcpu_pkg, vdpcpu_front, vdpcpu_queue, vdpcpu_back.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+----------------------------------------
//   in       | in_valid_i / in_ready_o | kind_i, data_byte_i, set_address_i,
//            |                         | status_byte_i
//   out      | out_valid_o/out_ready_i | read_data_o, address_now_o
//
// Cycles: one item per cycle sustained while results are taken; an accepted
// item is held in the queue until the back end pops it, and its result is
// registered in the output register, where it waits until it is taken.
// The single-port video RAM read sets the pace of read-ahead refills; the
// refilled byte is forwarded from the RAM output register, so a data read
// may follow a refill directly.
// Reset clears the address, the flip-flop, the read-ahead byte and all
// valid state; video RAM contents are undefined until written.
// Stalls: in_ready_o drops when the two-entry queue is full; the queue fills
// only while the output register holds an item that is not taken.
module vdp_cpu_port_vram_access_top import vdpcpu_pkg::*; #(
  parameter int unsigned ADDR_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] set_address_i,
  input  logic [7:0]  status_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [13:0] address_now_o
);

  cmd_t front_cmd;
  cmd_t queue_cmd;
  logic queue_full;
  logic queue_valid;
  logic queue_pop;
  logic accept;

  // Take an item whenever the queue has room; the front end decodes in the same cycle.
  assign in_ready_o = !queue_full;
  assign accept     = in_valid_i && in_ready_o;

  vdpcpu_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .set_address_i(set_address_i),
    .status_byte_i(status_byte_i),
    .cmd_o        (front_cmd)
  );

  // Hold decoded commands so the front end keeps taking items while results stall.
  vdpcpu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (accept),
    .push_cmd_i(front_cmd),
    .full_o    (queue_full),
    .pop_i     (queue_pop),
    .valid_o   (queue_valid),
    .pop_cmd_o (queue_cmd)
  );

  // Execute RAM accesses and present results.
  vdpcpu_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (queue_valid),
    .cmd_i        (queue_cmd),
    .pop_o        (queue_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_data_o  (read_data_o),
    .address_now_o(address_now_o)
  );

endmodule

@@ hdl/vdpcpu_checker.sv @@
// Port-level checker for the VDP CPU-port block, bound to the top level.
// Tracks items in flight between the two channels. No package dependency.
module vdpcpu_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  read_data_o,
  input logic [13:0] address_now_o
);

  logic [2:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 3'd0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 3'd1;
    end
  end

  // Hold a result until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(read_data_o) && $stable(address_now_o))
    else $error("result dropped or changed while stalled");

  // Never show a result for which no item was taken.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 3'd0)
    else $error("result without a pending item");

  // Queue plus output register hold at most three items.
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd3)
    else $error("too many items in flight");

  // With queue and output register full, refuse new items.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 3'd3 |-> !in_ready_o)
    else $error("item taken while full");

endmodule

bind vdp_cpu_port_vram_access_top vdpcpu_port_checker u_vdpcpu_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .read_data_o  (read_data_o),
  .address_now_o(address_now_o)
);
